// File: hdl/fsrv_pkg.sv
// Shared constants for the Fiat-Shamir round verify core.
// No dependencies.
`timescale 1ns / 1ps

package fsrv_pkg;

   localparam int MOD_WIDTH_DEFAULT = 20;

   localparam int MODULUS_RESET = 2;
   localparam int SECRET_RESET  = 1;

   typedef enum logic [0:0] {
      CSR_MODULUS = 1'b0,
      CSR_SECRET  = 1'b1
   } csr_index_type;

endpackage

// File: hdl/fsrv_modred.sv
// Pipelined modular reduction of several 2W-bit products by a shared modulus.
// One restoring step per stage; no package dependencies.
`timescale 1ns / 1ps

module fsrv_modred #(
   parameter int WIDTH      = 20,
   parameter int LANES      = 2,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [LANES-1:0][2*WIDTH-1:0] in_prod,
   input  logic [WIDTH-1:0]          in_mod,
   input  logic [SIDE_WIDTH-1:0]     in_side,
   output logic                      out_valid,
   output logic [LANES-1:0][WIDTH-1:0] out_rem,
   output logic [WIDTH-1:0]          out_mod,
   output logic [SIDE_WIDTH-1:0]     out_side
);

   localparam int STAGES = 2 * WIDTH;

   logic                             valid_ff [0:STAGES];
   logic [LANES-1:0][2*WIDTH-1:0]    prod_ff  [0:STAGES];
   logic [LANES-1:0][WIDTH-1:0]      rem_ff   [0:STAGES];
   logic [WIDTH-1:0]                 mod_ff   [0:STAGES];
   logic [SIDE_WIDTH-1:0]            side_ff  [0:STAGES];

   assign valid_ff[0] = in_valid;
   assign prod_ff[0]  = in_prod;
   assign rem_ff[0]   = '0;
   assign mod_ff[0]   = in_mod;
   assign side_ff[0]  = in_side;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [LANES-1:0][WIDTH-1:0] rem_in;

      // shift in the next product bit, subtract modulus once if it fits
      always_comb begin
         logic [WIDTH:0] trial;
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_ff[k][l], prod_ff[k][l][2*WIDTH-1]};
            if (trial >= {1'b0, mod_ff[k]}) begin
               trial = trial - {1'b0, mod_ff[k]};
            end
            rem_in[l] = trial[WIDTH-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         for (int l = 0; l < LANES; l++) begin
            prod_ff[k+1][l] <= {prod_ff[k][l][2*WIDTH-2:0], 1'b0};
         end
         rem_ff[k+1]  <= rem_in;
         mod_ff[k+1]  <= mod_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_rem   = rem_ff[STAGES];
   assign out_mod   = mod_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

// File: hdl/fiat_shamir_round_verify_core.sv
// Top level of the Fiat-Shamir identification round core.
// Depends on fsrv_pkg and fsrv_modred.
`timescale 1ns / 1ps

// Usage:
//  - Configure modulus (csr_index CSR_MODULUS) and secret (CSR_SECRET) with
//    csr_write while no item is in flight. Reset loads modulus 2, secret 1.
//  - Issue an item by raising start with req_nonce / req_challenge. busy is
//    always low: one item may enter every cycle.
//  - Each item yields one result, flagged by rsp_valid for one cycle.
//  - Pipeline: input register, products r*r, r*s, s*s, a reduction pipeline
//    of 2*MOD_WIDTH one-bit restoring steps, response select, products y*y
//    and x*v, a second reduction pipeline, output register. The two
//    reduction pipelines set the latency.
//  - Results cannot be held off; the strobe is a plain pulse.
//  - Reset clears all valid bits; items in flight are dropped.
//  - A modulus below two forces every reduced value to zero; accepted is set.
module fiat_shamir_round_verify_core #(
   parameter int MOD_WIDTH = fsrv_pkg::MOD_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  fsrv_pkg::csr_index_type csr_index,
   input  logic [MOD_WIDTH-1:0] csr_data,
   input  logic                 start,
   output logic                 busy,
   input  logic [MOD_WIDTH-1:0] req_nonce,
   input  logic                 req_challenge,
   output logic                 rsp_valid,
   output logic [MOD_WIDTH-1:0] rsp_commitment,
   output logic [MOD_WIDTH-1:0] rsp_response,
   output logic [MOD_WIDTH-1:0] rsp_response_squared,
   output logic [MOD_WIDTH-1:0] rsp_check_value,
   output logic                 rsp_accepted
);
   import fsrv_pkg::*;

   localparam int W = MOD_WIDTH;

   // configuration
   logic [W-1:0] modulus_ff, secret_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= W'(MODULUS_RESET);
         secret_ff  <= W'(SECRET_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_data;
            CSR_SECRET:  secret_ff  <= csr_data;
            default:     ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage A: input capture
   logic         a_valid_ff, a_e_ff;
   logic [W-1:0] a_r_ff, a_n_ff, a_s_ff;

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else       a_valid_ff <= start;
      a_r_ff <= req_nonce;
      a_e_ff <= req_challenge;
      a_n_ff <= modulus_ff;
      a_s_ff <= secret_ff;
   end

   // stage B: first products (lane 0 r*r, lane 1 r*s, lane 2 s*s)
   logic                    b_valid_ff, b_e_ff;
   logic [W-1:0]            b_r_ff, b_n_ff;
   logic [2:0][2*W-1:0]     b_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else       b_valid_ff <= a_valid_ff;
      b_prod_ff[0] <= (2*W)'(a_r_ff) * (2*W)'(a_r_ff);
      b_prod_ff[1] <= (2*W)'(a_r_ff) * (2*W)'(a_s_ff);
      b_prod_ff[2] <= (2*W)'(a_s_ff) * (2*W)'(a_s_ff);
      b_r_ff <= a_r_ff;
      b_e_ff <= a_e_ff;
      b_n_ff <= a_n_ff;
   end

   logic                r1_valid;
   logic [2:0][W-1:0]   r1_rem;
   logic [W-1:0]        r1_mod;
   logic [W:0]          r1_side;

   fsrv_modred #(.WIDTH(W), .LANES(3), .SIDE_WIDTH(W+1)) u_red1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_prod   (b_prod_ff),
      .in_mod    (b_n_ff),
      .in_side   ({b_e_ff, b_r_ff}),
      .out_valid (r1_valid),
      .out_rem   (r1_rem),
      .out_mod   (r1_mod),
      .out_side  (r1_side)
   );

   // stage C: pick response, force zero for degenerate modulus
   logic         c_valid_ff, c_e_ff;
   logic [W-1:0] c_x_ff, c_y_ff, c_v_ff, c_n_ff;
   logic         r1_degen;

   assign r1_degen = (r1_mod < W'(2));

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else       c_valid_ff <= r1_valid;
      c_x_ff <= r1_degen ? '0 : r1_rem[0];
      c_v_ff <= r1_degen ? '0 : r1_rem[2];
      if (r1_side[W]) c_y_ff <= r1_degen ? '0 : r1_rem[1];
      else            c_y_ff <= r1_side[W-1:0];
      c_e_ff <= r1_side[W];
      c_n_ff <= r1_mod;
   end

   // stage D: second products (lane 0 y*y, lane 1 x*v)
   logic                d_valid_ff, d_e_ff;
   logic [W-1:0]        d_x_ff, d_y_ff, d_n_ff;
   logic [1:0][2*W-1:0] d_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else       d_valid_ff <= c_valid_ff;
      d_prod_ff[0] <= (2*W)'(c_y_ff) * (2*W)'(c_y_ff);
      d_prod_ff[1] <= (2*W)'(c_x_ff) * (2*W)'(c_v_ff);
      d_x_ff <= c_x_ff;
      d_y_ff <= c_y_ff;
      d_e_ff <= c_e_ff;
      d_n_ff <= c_n_ff;
   end

   logic                r2_valid;
   logic [1:0][W-1:0]   r2_rem;
   logic [W-1:0]        r2_mod;
   logic [2*W:0]        r2_side;

   fsrv_modred #(.WIDTH(W), .LANES(2), .SIDE_WIDTH(2*W+1)) u_red2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid_ff),
      .in_prod   (d_prod_ff),
      .in_mod    (d_n_ff),
      .in_side   ({d_e_ff, d_y_ff, d_x_ff}),
      .out_valid (r2_valid),
      .out_rem   (r2_rem),
      .out_mod   (r2_mod),
      .out_side  (r2_side)
   );

   // output stage
   logic         r2_degen;
   logic [W-1:0] y2_val, chk_val;

   assign r2_degen = (r2_mod < W'(2));
   assign y2_val   = r2_degen ? '0 : r2_rem[0];
   assign chk_val  = r2_side[2*W] ? (r2_degen ? '0 : r2_rem[1]) : r2_side[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= r2_valid;
      rsp_commitment       <= r2_side[W-1:0];
      rsp_response         <= r2_side[2*W-1:W];
      rsp_response_squared <= y2_val;
      rsp_check_value      <= chk_val;
      rsp_accepted         <= (y2_val == chk_val);
   end

endmodule
